FILE: hdl/pidpc_pkg.sv
// ----------------------------------------------------------------------------
// pidpc_pkg - shared types and constants of the position pid controller
// Transaction payloads, register indexes and the saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package pidpc_pkg;

    // field widths
    localparam int POS_W    = 24;
    localparam int DELTA_W  = 32;
    localparam int ERR_W    = 32;
    localparam int DERIV_W  = 33;
    localparam int GAIN_W   = 16;
    localparam int BAND_W   = 31;
    localparam int NMOT_W   = 3;
    localparam int SPEED_W  = 8;
    localparam int CFG_W    = 31;
    localparam int CFG_IDX_W = 3;

    // number of position inputs on the item
    localparam int POS_INPUTS = 4;

    // drive clamp
    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 8'sd85;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = -8'sd85;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KP         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_BAND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_MOTORS = 3'd4;

    // item commands
    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_MOVE = 1'b1;

    // reciprocal of three: q = (a * RECIP3) >> RECIP3_SHIFT, exact for a < 2^25
    localparam int RECIP3_SHIFT = 27;
    localparam logic [26:0] RECIP3 = 27'h2AAAAAB;

    // input transaction payload
    typedef struct packed {
        logic                      cmd;
        logic signed [POS_W-1:0]   pos_a;
        logic signed [POS_W-1:0]   pos_b;
        logic signed [POS_W-1:0]   pos_c;
        logic signed [POS_W-1:0]   pos_d;
        logic signed [DELTA_W-1:0] target_delta;
    } in_item_t;

    // output transaction payload
    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic                      drive_valid;
        logic signed [ERR_W-1:0]   err_now;
        logic                      at_target;
        logic                      stopped;
    } out_item_t;

    // saturate a 33-bit signed value to 32 bits
    function automatic logic signed [ERR_W-1:0] sat32(input logic signed [ERR_W:0] v);
        logic signed [ERR_W-1:0] r;
        if (v[ERR_W] != v[ERR_W-1])
            r = v[ERR_W] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
        else
            r = v[ERR_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/pidpc_if.sv
// ----------------------------------------------------------------------------
// pidpc_if - valid/ready channels of the position pid controller
// One interface for the input items and one for the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface pidpc_in_if;
    import pidpc_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pidpc_out_if;
    import pidpc_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/pid_position_controller.sv
// ----------------------------------------------------------------------------
// pid_position_controller - position pid loop with integral reset and clamp
// Averages encoder positions, forms error, integral and derivative and drives
// a clamped speed command through one shared multiplier.
// ----------------------------------------------------------------------------
// A control step transaction passes through the sequencer from acceptance to
// the output register: one position is summed per cycle, then the averaging
// divide, error, integral and the three gain products each take one pass
// through the single shared 33 x 27 bit multiplier or the adder behind it,
// and a move transaction skips these steps. in_ch.ready is high only while
// the sequencer is idle; a finished result waits in the output register, and
// the next transaction may be accepted while it waits.
`default_nettype none

module pid_position_controller #(
    parameter int MAX_MOTORS     = 4,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  wire                               clk,
    input  wire                               rst_n,
    pidpc_in_if.sink                          in_ch,
    pidpc_out_if.source                       out_ch,
    input  wire                               cfg_we,
    input  wire [pidpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [pidpc_pkg::CFG_W-1:0]        cfg_data
);
    import pidpc_pkg::*;

    // derived sizes
    localparam int LIM    = (MAX_MOTORS < POS_INPUTS) ? MAX_MOTORS : POS_INPUTS;
    localparam int SUM_W  = POS_W + 2;
    localparam int AVG_W  = POS_W + 1;
    localparam int MX_W   = 33;
    localparam int MY_W   = 27;
    localparam int PROD_W = MX_W + MY_W;
    localparam int ACC_W  = 52;
    localparam logic [ACC_W-1:0] ROUND_BIAS =
        ACC_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SUM  = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_AVG  = 4'd3;
    localparam logic [3:0] S_ERR  = 4'd4;
    localparam logic [3:0] S_INT  = 4'd5;
    localparam logic [3:0] S_MP   = 4'd6;
    localparam logic [3:0] S_MI   = 4'd7;
    localparam logic [3:0] S_MD   = 4'd8;
    localparam logic [3:0] S_MACC = 4'd9;
    localparam logic [3:0] S_MOVE = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    // configuration registers
    logic signed [GAIN_W-1:0] kp_reg, ki_reg, kd_reg;
    logic [BAND_W-1:0]        slow_band_reg;
    logic [NMOT_W-1:0]        num_motors_reg;

    // sequencer and datapath registers
    logic [3:0]                state_reg, state_next;
    in_item_t                  item_reg, item_next;
    logic [1:0]                cnt_reg, cnt_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [AVG_W-1:0]   avg_reg, avg_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [ERR_W-1:0]   target_reg, target_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [ERR_W-1:0]   prev_err_reg, prev_err_next;
    logic signed [DERIV_W-1:0] deriv_reg, deriv_next;
    logic signed [ERR_W-1:0]   integ_reg, integ_next;
    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_data_reg, out_data_next;

    // combinational helpers
    logic [2:0]                n_eff;
    logic [1:0]                n_last;
    logic signed [POS_W-1:0]   pos_sel;
    logic                      sum_neg;
    logic [SUM_W-1:0]          sum_abs;
    logic [SUM_W-1:0]          quot;
    logic signed [MX_W-1:0]    mul_x;
    logic signed [MY_W-1:0]    mul_y;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [ERR_W-1:0]   integ_sum;
    logic signed [ERR_W:0]     err_wide;
    logic [ERR_W-1:0]          err_mag;
    logic signed [ACC_W-1:0]   acc_adj;
    logic signed [ACC_W-1:0]   scaled;
    logic signed [SPEED_W-1:0] speed_c;
    logic                      out_free;

    // effective motor count: zero reads as one, capped at the limit
    always_comb
    begin
        if (num_motors_reg == 3'd0)
            n_eff = 3'd1;
        else if (32'(num_motors_reg) > LIM)
            n_eff = 3'(LIM);
        else
            n_eff = num_motors_reg;
        n_last = 2'(n_eff - 3'd1);
    end

    // position selected by the summing counter
    always_comb
    begin
        case (cnt_reg)
            2'd0:    pos_sel = item_reg.pos_a;
            2'd1:    pos_sel = item_reg.pos_b;
            2'd2:    pos_sel = item_reg.pos_c;
            default: pos_sel = item_reg.pos_d;
        endcase
    end

    // magnitude of the position sum and the quotient by the motor count
    always_comb
    begin
        sum_neg = sum_reg[SUM_W-1];
        sum_abs = sum_neg ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        case (n_eff)
            3'd1:    quot = sum_abs;
            3'd2:    quot = sum_abs >> 1;
            3'd3:    quot = prod_reg[RECIP3_SHIFT +: SUM_W];
            default: quot = sum_abs >> 2;
        endcase
    end

    // shared multiplier operand selection
    always_comb
    begin
        case (state_reg)
            S_DIV:
            begin
                mul_x = MX_W'(sum_abs);
                mul_y = RECIP3;
            end
            S_MP:
            begin
                mul_x = MX_W'(err_reg);
                mul_y = MY_W'(kp_reg);
            end
            S_MI:
            begin
                mul_x = MX_W'(integ_reg);
                mul_y = MY_W'(ki_reg);
            end
            S_MD:
            begin
                mul_x = deriv_reg;
                mul_y = MY_W'(kd_reg);
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
        mul_p = mul_x * mul_y;
    end

    // integral update and clear test
    always_comb
    begin
        integ_sum = sat32(33'(integ_reg) + 33'(err_reg));
        err_wide  = err_reg[ERR_W-1] ? -33'(err_reg) : 33'(err_reg);
        err_mag   = err_wide[ERR_W-1:0];
    end

    // scale the gain sum toward zero and clamp the drive
    always_comb
    begin
        acc_adj = acc_reg + (acc_reg[ACC_W-1] ? $signed(ROUND_BIAS) : $signed(ACC_W'(0)));
        scaled  = acc_adj >>> GAIN_FRAC_BITS;
        if (scaled > ACC_W'(SPEED_MAX))
            speed_c = SPEED_MAX;
        else if (scaled < ACC_W'(SPEED_MIN))
            speed_c = SPEED_MIN;
        else
            speed_c = scaled[SPEED_W-1:0];
    end

    assign out_free = !out_valid_reg || out_ch.ready;

    // sequencer next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        avg_next       = avg_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        target_next    = target_reg;
        err_next       = err_reg;
        prev_err_next  = prev_err_reg;
        deriv_next     = deriv_reg;
        integ_next     = integ_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_data_next  = out_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    item_next  = in_ch.data;
                    cnt_next   = 2'd0;
                    sum_next   = '0;
                    state_next = (in_ch.data.cmd == CMD_MOVE) ? S_MOVE : S_SUM;
                end
            end
            S_SUM:
            begin
                sum_next = sum_reg + SUM_W'(pos_sel);
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == n_last)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                prod_next  = mul_p;
                state_next = S_AVG;
            end
            S_AVG:
            begin
                avg_next   = sum_neg ? AVG_W'(-quot) : AVG_W'(quot);
                state_next = S_ERR;
            end
            S_ERR:
            begin
                err_next   = sat32(33'(target_reg) - 33'(avg_reg));
                state_next = S_INT;
            end
            S_INT:
            begin
                if (err_reg == '0 || err_mag > {1'b0, slow_band_reg})
                    integ_next = '0;
                else
                    integ_next = integ_sum;
                deriv_next    = 33'(err_reg) - 33'(prev_err_reg);
                prev_err_next = err_reg;
                state_next    = S_MP;
            end
            S_MP:
            begin
                prod_next  = mul_p;
                state_next = S_MI;
            end
            S_MI:
            begin
                acc_next   = prod_reg[ACC_W-1:0];
                prod_next  = mul_p;
                state_next = S_MD;
            end
            S_MD:
            begin
                acc_next   = acc_reg + prod_reg[ACC_W-1:0];
                prod_next  = mul_p;
                state_next = S_MACC;
            end
            S_MACC:
            begin
                acc_next   = acc_reg + prod_reg[ACC_W-1:0];
                state_next = S_DONE;
            end
            S_MOVE:
            begin
                target_next = sat32(33'(target_reg) + 33'(item_reg.target_delta));
                err_next    = sat32(33'(err_reg) + 33'(item_reg.target_delta));
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                // load the result once the output register is free
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.speed       = (item_reg.cmd == CMD_MOVE) ? '0 : speed_c;
                    out_data_next.drive_valid = (item_reg.cmd == CMD_STEP);
                    out_data_next.err_now     = err_reg;
                    out_data_next.at_target   = (err_reg == '0);
                    out_data_next.stopped     = (deriv_reg == '0);
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and loop state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            target_reg     <= '0;
            err_reg        <= '0;
            prev_err_reg   <= '0;
            deriv_reg      <= '0;
            integ_reg      <= '0;
            kp_reg         <= '0;
            ki_reg         <= '0;
            kd_reg         <= '0;
            slow_band_reg  <= '0;
            num_motors_reg <= 3'd1;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            target_reg    <= target_next;
            err_reg       <= err_next;
            prev_err_reg  <= prev_err_next;
            deriv_reg     <= deriv_next;
            integ_reg     <= integ_next;
            // configuration writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_KP:         kp_reg         <= cfg_data[GAIN_W-1:0];
                    REG_KI:         ki_reg         <= cfg_data[GAIN_W-1:0];
                    REG_KD:         kd_reg         <= cfg_data[GAIN_W-1:0];
                    REG_SLOW_BAND:  slow_band_reg  <= cfg_data[BAND_W-1:0];
                    REG_NUM_MOTORS: num_motors_reg <= cfg_data[NMOT_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        cnt_reg      <= cnt_next;
        sum_reg      <= sum_next;
        avg_reg      <= avg_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    // channel outputs
    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

endmodule

`default_nettype wire
